>>> sv/swp_pkg.sv
// Shared types for the smoothstep weight product unit.
`default_nettype none
package swp_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_UPD,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

>>> sv/smoothstep_weight_product_unit.sv
// Running product of smoothstep weights over a run of weight sets.
//
// Input stream (s_axis): one weight set per beat, packed as min, mid, max and
// input value, lowest bits first; s_axis_tlast marks the final set of a run.
// Output stream (m_axis): one beat per run, sent after the set with tlast,
// holding the Q1.(PRODUCT_FRAC_BITS) product and the rejected flag.
// Sets are accepted one at a time, only while the unit is idle. When a
// set's factor has to be computed, it goes through a restoring divider
// that makes one quotient bit per cycle, then three passes through one
// shared multiplier. A set whose input equals mid, lies outside min..max,
// or follows a rejection skips the divider and the multiplier.
// The result sits in an output register, so the next run is taken in while
// the receiver stalls; only the next last set waits for that register to
// empty. Reset empties the output register and returns the product to 1.0
// with the rejected flag clear.
`default_nettype none
module smoothstep_weight_product_unit #(
	parameter int WEIGHT_WIDTH      = 16,
	parameter int PRODUCT_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic      s_axis_tready,
	// min_weight, mid_weight, max_weight, in_weight (lowest bit up), zero pad
	input  wire logic [((4 * WEIGHT_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	input  wire logic s_axis_tlast,
	output logic      m_axis_tvalid,
	input  wire logic m_axis_tready,
	// product_weight, rejected (lowest bit up), zero pad
	output logic [((PRODUCT_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int W     = WEIGHT_WIDTH;
	localparam int F     = PRODUCT_FRAC_BITS;
	localparam int MW    = F + 2;
	localparam int CW    = $clog2(F + 1);
	localparam int OW    = ((F + 2 + 7) / 8) * 8;
	localparam logic [F:0]    ONE_Q   = (F + 1)'(1) << F;
	localparam logic [MW-1:0] THREE_Q = MW'(3) << F;

	swp_pkg::state_t state_q, state_d;

	logic signed [W-1:0] lo_q, mid_q, hi_q, val_q;
	logic                last_q;
	logic [W-1:0]        den_q;
	logic [W:0]          rem_q;
	logic [F-1:0]        x_q;
	logic [CW-1:0]       cnt_q;
	logic [2*MW-1:0]     mul_q;
	logic [F:0]          rp_q;
	logic                zeroed_q;
	logic                out_valid_q;
	logic [F:0]          out_prod_q;
	logic                out_rej_q;

	// prep-stage decode
	logic                in_range, at_mid, below, go_div;
	logic signed [W:0]   num_diff, den_diff;
	// divider step
	logic [W:0]          rem_sh;
	logic                rem_ge;
	// shared multiplier
	logic [MW-1:0]       mul_a, mul_b;
	logic                out_free, out_load;

	always_comb begin
		in_range = (val_q >= lo_q) && (val_q <= hi_q);
		at_mid   = (val_q == mid_q);
		below    = (val_q < mid_q);
		// edge is min below mid, max above it; both differences are non-negative for an input in range
		num_diff = below ? ((W + 1)'(val_q) - (W + 1)'(lo_q))
		                 : ((W + 1)'(hi_q) - (W + 1)'(val_q));
		den_diff = below ? ((W + 1)'(mid_q) - (W + 1)'(lo_q))
		                 : ((W + 1)'(hi_q) - (W + 1)'(mid_q));
		go_div   = !zeroed_q && in_range && !at_mid;
		rem_sh   = {rem_q[W-1:0], 1'b0};
		rem_ge   = rem_sh >= {1'b0, den_q};
		out_free = !out_valid_q || m_axis_tready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swp_pkg::S_IDLE: if (s_axis_tvalid) state_d = swp_pkg::S_PREP;
			swp_pkg::S_PREP: state_d = go_div ? swp_pkg::S_DIV : swp_pkg::S_DONE;
			swp_pkg::S_DIV:  if (cnt_q == CW'(1)) state_d = swp_pkg::S_MUL1;
			swp_pkg::S_MUL1: state_d = swp_pkg::S_MUL2;
			swp_pkg::S_MUL2: state_d = swp_pkg::S_MUL3;
			swp_pkg::S_MUL3: state_d = swp_pkg::S_UPD;
			swp_pkg::S_UPD:  state_d = swp_pkg::S_DONE;
			swp_pkg::S_DONE: if (!last_q || out_free) state_d = swp_pkg::S_IDLE;
			default:         state_d = swp_pkg::S_IDLE;
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			swp_pkg::S_IDLE: s_axis_tready = 1'b1;
			swp_pkg::S_MUL1: begin
				mul_a = MW'(x_q);
				mul_b = MW'(x_q);
			end
			swp_pkg::S_MUL2: begin
				// x2 times (3 - 2x)
				mul_a = MW'(mul_q[2*F-1:F]);
				mul_b = THREE_Q - {1'b0, x_q, 1'b0};
			end
			swp_pkg::S_MUL3: begin
				mul_a = MW'(rp_q);
				mul_b = MW'(mul_q[2*F-1:F]);
			end
			swp_pkg::S_DONE: out_load = last_q && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swp_pkg::S_IDLE;
			rp_q        <= ONE_Q;
			zeroed_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == swp_pkg::S_PREP) begin
				cnt_q <= CW'(F);
				if (!zeroed_q && !in_range) begin
					rp_q     <= '0;
					zeroed_q <= 1'b1;
				end
			end
			if (state_q == swp_pkg::S_DIV)
				cnt_q <= cnt_q - CW'(1);
			if (state_q == swp_pkg::S_UPD)
				rp_q <= mul_q[2*F:F];
			if (out_load) begin
				out_valid_q <= 1'b1;
				rp_q        <= ONE_Q;
				zeroed_q    <= 1'b0;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			lo_q   <= s_axis_tdata[W-1:0];
			mid_q  <= s_axis_tdata[2*W-1:W];
			hi_q   <= s_axis_tdata[3*W-1:2*W];
			val_q  <= s_axis_tdata[4*W-1:3*W];
			last_q <= s_axis_tlast;
		end
		if (state_q == swp_pkg::S_PREP) begin
			rem_q <= {1'b0, num_diff[W-1:0]};
			den_q <= den_diff[W-1:0];
		end
		if (state_q == swp_pkg::S_DIV) begin
			rem_q <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			x_q   <= {x_q[F-2:0], rem_ge};
		end
		if (state_q == swp_pkg::S_MUL1 || state_q == swp_pkg::S_MUL2 ||
		    state_q == swp_pkg::S_MUL3)
			mul_q <= mul_a * mul_b;
		if (out_load) begin
			out_prod_q <= rp_q;
			out_rej_q  <= zeroed_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OW'({out_rej_q, out_prod_q});

	a_zeroed_product: assert property (@(posedge clk) disable iff (!arst_n)
		zeroed_q |-> rp_q == '0)
		else $error("rejected run holds a nonzero product");

	a_product_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= ONE_Q)
		else $error("running product above 1.0");

	a_rejected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_rej_q) |-> out_prod_q == '0)
		else $error("rejected result with nonzero product");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swp_pkg::S_DIV) |-> rem_q < {1'b0, den_q})
		else $error("divider remainder not below divisor");

	a_fresh_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (rp_q == ONE_Q && !zeroed_q))
		else $error("run state not restored after result");

endmodule
`default_nettype wire
